/* design/lbp_pkg.sv */
// Shared types and constants for the 3x3 local binary pattern stream unit.
// No dependencies; compiled first.
package lbp_pkg;

    // Line store geometry
    localparam int COL_W     = 11;
    localparam int MAX_WIDTH = 1 << COL_W;
    localparam int ROW_W     = 12;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // Register reset values and bounds
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);
    localparam logic [CFG_W-1:0] MIN_DIM          = CFG_W'(3);
    localparam logic [CFG_W-1:0] MAX_DIM_W        = CFG_W'(MAX_WIDTH);

    typedef logic [PIX_W-1:0]     pixel_t;
    typedef logic [PIX_W-1:0]     code_t;
    typedef logic [ROW_W-1:0]     row_t;
    typedef logic [COL_W-1:0]     col_t;
    typedef logic [CFG_W-1:0]     cfg_data_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

endpackage

/* design/lbp_pix_if.sv */
// Pixel input channel: valid/ready handshake carrying one grey pixel.
// Depends on lbp_pkg.
interface lbp_pix_if;
    import lbp_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

/* design/lbp_res_if.sv */
// Result channel: valid/ready handshake carrying one LBP code and its centre.
// Depends on lbp_pkg.
interface lbp_res_if;
    import lbp_pkg::*;

    logic  valid;
    logic  ready;
    code_t code;
    row_t  centre_row;
    col_t  centre_col;
    logic  frame_done;

    modport source (output valid, output code, output centre_row, output centre_col,
                    output frame_done, input ready);
    modport sink   (input valid, input code, input centre_row, input centre_col,
                    input frame_done, output ready);
endinterface

/* design/lbp_cfg_if.sv */
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on lbp_pkg.
interface lbp_cfg_if;
    import lbp_pkg::*;

    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/lbp_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/lbp_code_3x3_stream_unit.sv */
// 3x3 local binary pattern over a raster pixel stream.
// Depends on lbp_pkg, lbp_pix_if, lbp_res_if, lbp_cfg_if and lbp_ram.
//
// Usage:
//   pix  - grey pixels in raster order, frame_width x frame_height per frame.
//   res  - one item per interior centre: 8-bit code, centre row/column and
//          frame_done on the last interior code of the frame. Border pixels
//          produce no item.
//   cfg  - register writes, index 0 frame_width, index 1 frame_height; always
//          ready. Write only while the block is idle.
// Throughput: one pixel per cycle, sustained, for any width and height, while res is taken.
// Pipeline: an accepted pixel enters the read stage together with its line store
//   read, then its code is registered into the output as the read stage advances.
// The line store is one 2048 x 16-bit RAM holding the two previous rows per
//   column; each pixel does one read on acceptance and one write as it
//   leaves the read stage.
// Reset: counters restart at the first pixel of a frame, registers return
//   to 640 x 480, no item is pending. The line store needs no clearing.
// Stall: while res is full and not taken, one more pixel is taken into the
//   read stage, then pix.ready drops until the result is taken.
module lbp_code_3x3_stream_unit (
    input  logic      clk,
    input  logic      rst_n,
    lbp_pix_if.sink   pix,
    lbp_res_if.source res,
    lbp_cfg_if.sink   cfg
);
    import lbp_pkg::*;

    cfg_data_t frame_width_reg;
    cfg_data_t frame_height_reg;
    cfg_data_t eff_w;
    cfg_data_t eff_h;

    col_t      col_count_reg;
    col_t      col_count_next;
    row_t      row_count_reg;
    row_t      row_count_next;

    logic      col_wrap;
    row_t      row_pre;
    col_t      cur_col;
    row_t      cur_row;
    cfg_data_t col_inc;
    row_t      row_inc;
    logic      end_row;
    logic      in_accept;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    logic      s1_adv;
    pixel_t    s1_pixel_reg;
    col_t      s1_col_reg;
    row_t      s1_row_reg;
    logic      s1_emit_reg;
    logic      s1_last_reg;

    logic [2*PIX_W-1:0] ram_rdata;
    pixel_t    top_px;
    pixel_t    mid_px;
    pixel_t    win0_reg [3];
    pixel_t    win1_reg [3];
    code_t     code_calc;

    logic      out_valid_reg;
    logic      out_valid_next;
    code_t     code_reg;
    row_t      centre_row_reg;
    col_t      centre_col_reg;
    logic      frame_done_reg;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    // Clamped frame size
    always_comb
    begin
        if (frame_width_reg < MIN_DIM)
            eff_w = MIN_DIM;
        else if (frame_width_reg > MAX_DIM_W)
            eff_w = MAX_DIM_W;
        else
            eff_w = frame_width_reg;
        eff_h = (frame_height_reg < MIN_DIM) ? MIN_DIM : frame_height_reg;
    end

    // Position of the incoming pixel and counter advance
    always_comb
    begin
        col_wrap       = CFG_W'(col_count_reg) >= eff_w;
        row_pre        = col_wrap ? row_count_reg + ROW_W'(1) : row_count_reg;
        cur_col        = col_wrap ? '0 : col_count_reg;
        cur_row        = (row_pre >= eff_h) ? '0 : row_pre;
        col_inc        = CFG_W'(cur_col) + CFG_W'(1);
        row_inc        = cur_row + ROW_W'(1);
        end_row        = col_inc >= eff_w;
        col_count_next = end_row ? '0 : col_inc[COL_W-1:0];
        if (end_row)
            row_count_next = (row_inc >= eff_h) ? '0 : row_inc;
        else
            row_count_next = cur_row;
    end

    // Handshake: the read stage moves on whenever the output register frees up
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || res.ready);
    assign pix.ready = !s1_valid_reg || s1_adv;
    assign in_accept = pix.valid && pix.ready;

    always_comb
    begin
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (in_accept)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
            end
        end
    end

    // Read stage payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg <= pix.pixel;
            s1_col_reg   <= cur_col;
            s1_row_reg   <= cur_row;
            s1_emit_reg  <= (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
            s1_last_reg  <= (cur_row == eff_h - CFG_W'(1))
                            && (CFG_W'(cur_col) == eff_w - CFG_W'(1));
        end
    end

    // Line store: {row r-2, row r-1} per column, shifted up on write
    lbp_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata ({mid_px, s1_pixel_reg}),
        .re    (in_accept),
        .raddr (cur_col),
        .rdata (ram_rdata)
    );

    assign top_px = ram_rdata[2*PIX_W-1:PIX_W];
    assign mid_px = ram_rdata[PIX_W-1:0];

    // Window columns: win0 oldest, win1 middle; the newest column is the RAM output and the read stage pixel
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            win0_reg    <= win1_reg;
            win1_reg[0] <= top_px;
            win1_reg[1] <= mid_px;
            win1_reg[2] <= s1_pixel_reg;
        end
    end

    // Code: bit 7 left, counter-clockwise down to bit 0 above-left
    always_comb
    begin
        code_calc[7] = win0_reg[1]  > win1_reg[1];
        code_calc[6] = win0_reg[2]  > win1_reg[1];
        code_calc[5] = win1_reg[2]  > win1_reg[1];
        code_calc[4] = s1_pixel_reg > win1_reg[1];
        code_calc[3] = mid_px       > win1_reg[1];
        code_calc[2] = top_px       > win1_reg[1];
        code_calc[1] = win1_reg[0]  > win1_reg[1];
        code_calc[0] = win0_reg[0]  > win1_reg[1];
    end

    // Output register
    always_comb
    begin
        if (s1_adv && s1_emit_reg)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit_reg)
        begin
            code_reg       <= code_calc;
            centre_row_reg <= s1_row_reg - ROW_W'(1);
            centre_col_reg <= s1_col_reg - COL_W'(1);
            frame_done_reg <= s1_last_reg;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.code       = code_reg;
    assign res.centre_row = centre_row_reg;
    assign res.centre_col = centre_col_reg;
    assign res.frame_done = frame_done_reg;

endmodule

/* design/lbp_chk.sv */
// Port-level checker for the LBP stream unit, attached by bind.
// Depends on lbp_pkg and lbp_code_3x3_stream_unit.
module lbp_chk (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input lbp_pkg::code_t       code,
    input lbp_pkg::row_t        centre_row,
    input lbp_pkg::col_t        centre_col,
    input logic                 frame_done
);
    import lbp_pkg::*;

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code) && $stable(centre_row)
            && $stable(centre_col) && $stable(frame_done))
        else $error("result changed while stalled");

    // Pixels are refused only while a result waits on a stalled receiver
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // A new result traces back to an accepted pixel through the read stage and the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching pixel");

    // Centres on the top row or the left column are never coded
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> centre_row != '0 && centre_col != '0)
        else $error("border centre reported");

endmodule

bind lbp_code_3x3_stream_unit lbp_chk u_lbp_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pix.valid),
    .in_ready   (pix.ready),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .code       (res.code),
    .centre_row (res.centre_row),
    .centre_col (res.centre_col),
    .frame_done (res.frame_done)
);
